>>> design/ffha_pkg.sv
// Shared types, constants and helpers of the first-fit heap allocator.
package ffha_pkg;

   localparam int MAX_HEAP_BYTES = 65536;
   localparam int HEADER_BYTES   = 16;
   localparam int HEAP_RESET     = 4096;
   localparam int MIN_HEAP       = 64;

   // Heap is handled in 4-byte words throughout
   localparam int DEPTH       = MAX_HEAP_BYTES / 4;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int OFF_W       = ADDR_W + 1;
   localparam int SIZE_W      = ADDR_W;
   localparam int HDR_W       = HEADER_BYTES / 4;
   localparam int SPLIT_MIN_W = HDR_W + 1;
   localparam int BYTES_W     = 17;
   localparam int PTR_W       = 16;

   localparam logic [1:0] KIND_ALLOC   = 2'd0;
   localparam logic [1:0] KIND_FREE    = 2'd1;
   localparam logic [1:0] KIND_REALLOC = 2'd2;

   typedef enum logic [1:0] {
      STATUS_DONE,
      STATUS_NO_FIT,
      STATUS_BAD_OFFSET,
      STATUS_ZERO_SIZE
   } status_type;

   typedef enum logic [1:0] {
      MODE_ALLOC,
      MODE_SHRINK,
      MODE_GROW,
      MODE_FREE
   } mode_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_INIT,
      ST_IDLE,
      ST_LOOK,
      ST_LOOK_CHK,
      ST_F_MARK,
      ST_A_RD,
      ST_A_CHK,
      ST_SPLIT,
      ST_SPLIT_B,
      ST_POST,
      ST_U_RD,
      ST_U_CHK,
      ST_U_NX,
      ST_U_NCHK,
      ST_U_WB,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic              free;
      logic [SIZE_W-1:0] size;
   } entry_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      entry_type         wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

   typedef struct packed {
      logic [OFF_W-1:0]  base;
      logic [SIZE_W-1:0] len;
      logic [OFF_W-1:0]  need;
   } alu_in_type;

   typedef struct packed {
      logic [OFF_W:0]    step;
      logic              fits;
      logic              split_ok;
      logic [SIZE_W-1:0] rest;
      logic [OFF_W-1:0]  tail;
   } alu_out_type;

   typedef struct packed {
      status_type       status;
      logic [PTR_W-1:0] offset;
      logic             moved;
   } rsp_type;

   // Heap size in words: rounded down to 4 bytes, saturated to the legal range
   function automatic logic [OFF_W-1:0] heap_words(logic [BYTES_W-1:0] v);
      logic [BYTES_W-1:0] r;
      r = {v[BYTES_W-1:2], 2'b00};
      if (r < BYTES_W'(MIN_HEAP)) r = BYTES_W'(MIN_HEAP);
      if (r > BYTES_W'(MAX_HEAP_BYTES)) r = BYTES_W'(MAX_HEAP_BYTES);
      return r[OFF_W+1:2];
   endfunction

endpackage

>>> design/ffha_alu.sv
// Shared walk and fit unit: next block offset, fit and split tests.
module ffha_alu import ffha_pkg::*; (
   input  alu_in_type  alu_in,
   output alu_out_type alu_out
);

   logic [OFF_W:0] need_split;

   assign need_split = {1'b0, alu_in.need} + (OFF_W+1)'(SPLIT_MIN_W);

   // Offset just past a block of the given payload length
   assign alu_out.step = {1'b0, alu_in.base} + (OFF_W+1)'(HDR_W)
                         + (OFF_W+1)'(alu_in.len);

   // Fit and split tests against the rounded request
   assign alu_out.fits     = {1'b0, alu_in.len} >= alu_in.need;
   assign alu_out.split_ok = (OFF_W+1)'(alu_in.len) >= need_split;

   // Remainder block after a split
   assign alu_out.rest = alu_in.len - alu_in.need[SIZE_W-1:0] - SIZE_W'(HDR_W);
   assign alu_out.tail = alu_in.base + OFF_W'(HDR_W) + alu_in.need;

endmodule

>>> design/ffha_ram.sv
// Block header store: one write port, one read port with registered data.
module ffha_ram import ffha_pkg::*; (
   input  logic        clock,
   input  mem_req_type mem_req,
   output entry_type   rdata
);

   entry_type mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rdata <= mem[mem_req.raddr];
   end

endmodule

>>> design/ffha_ctrl.sv
// Sequencer and datapath registers of the allocator: walk, split and merge.
module ffha_ctrl import ffha_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_kind,
   input  logic [PTR_W-1:0]    req_payload_offset,
   input  logic [BYTES_W-1:0]  req_request_bytes,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [BYTES_W-1:0]  csr_heap_bytes,
   input  logic                rsp_free,
   output logic                rsp_load,
   output rsp_type             rsp_data,
   output alu_in_type          alu_in,
   input  alu_out_type         alu_out,
   output mem_req_type         mem_req,
   input  entry_type           rdata
);

   state_type         state_ff, state_in;
   logic [OFF_W-1:0]  heap_w_ff, heap_w_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   mode_type          mode_ff, mode_in;
   logic [PTR_W-1:0]  p_ff, p_in;
   logic [OFF_W-1:0]  need_ff, need_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   entry_type         cur_ff, cur_in;
   logic [OFF_W-1:0]  old_off_ff, old_off_in;
   logic [SIZE_W-1:0] old_size_ff, old_size_in;
   logic              keep_free_ff, keep_free_in;
   logic [OFF_W-1:0]  nx_ff, nx_in;
   status_type        status_ff, status_in;
   logic [PTR_W-1:0]  res_ff, res_in;
   logic              moved_ff, moved_in;

   logic              req_xfer, csr_xfer;
   logic [ADDR_W-1:0] look_off;
   logic              p_ok;
   logic              at_end, step_end, merge_ok;
   logic [BYTES_W:0]  need_sum;
   logic [ADDR_W-1:0] grant_w;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign req_xfer  = req_valid & req_ready;
   assign csr_xfer  = csr_valid & csr_ready;

   // Header position named by a payload offset, and its sanity checks
   assign look_off = p_ff[PTR_W-1:2] - ADDR_W'(HDR_W);
   assign p_ok     = (p_ff >= PTR_W'(HEADER_BYTES)) && (p_ff[1:0] == 2'b00)
                     && ({1'b0, look_off} < heap_w_ff);

   assign at_end   = off_ff >= heap_w_ff;
   assign step_end = alu_out.step >= {1'b0, heap_w_ff};
   assign merge_ok = rdata.start & rdata.free;
   assign need_sum = {1'b0, req_request_bytes} + (BYTES_W+1)'(3);
   assign grant_w  = off_ff[ADDR_W-1:0] + ADDR_W'(HDR_W);

   // Shared unit operands
   always_comb begin
      alu_in.base = off_ff;
      alu_in.len  = cur_ff.size;
      alu_in.need = need_ff;
      if (state_ff == ST_U_NCHK) begin
         alu_in.base = OFF_W'(cur_ff.size);
      end
      if (state_ff == ST_A_CHK || state_ff == ST_U_CHK || state_ff == ST_LOOK_CHK
          || state_ff == ST_U_NCHK) begin
         alu_in.len = rdata.size;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:    if (clr_ff == ADDR_W'(DEPTH-1)) state_in = ST_INIT;
         ST_INIT:     state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_kind == KIND_FREE) begin
                  state_in = (req_payload_offset == '0) ? ST_DONE : ST_LOOK;
               end else if (req_kind == KIND_ALLOC
                            || (req_kind == KIND_REALLOC && req_payload_offset == '0)) begin
                  state_in = (req_request_bytes == '0) ? ST_DONE : ST_A_RD;
               end else if (req_kind == KIND_REALLOC) begin
                  state_in = ST_LOOK;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_LOOK:     state_in = p_ok ? ST_LOOK_CHK : ST_DONE;
         ST_LOOK_CHK: begin
            if (!rdata.start) state_in = ST_DONE;
            else if (mode_ff == MODE_FREE) state_in = ST_F_MARK;
            else if (alu_out.fits) state_in = ST_SPLIT;
            else state_in = ST_A_RD;
         end
         ST_F_MARK:   state_in = ST_U_RD;
         ST_A_RD:     state_in = at_end ? ST_DONE : ST_A_CHK;
         ST_A_CHK:    state_in = (rdata.free && alu_out.fits) ? ST_SPLIT : ST_A_RD;
         ST_SPLIT:    state_in = alu_out.split_ok ? ST_SPLIT_B : ST_POST;
         ST_SPLIT_B:  state_in = ST_POST;
         ST_POST:     state_in = (mode_ff == MODE_GROW) ? ST_U_RD : ST_DONE;
         ST_U_RD:     state_in = at_end ? ST_DONE : ST_U_CHK;
         ST_U_CHK:    state_in = rdata.free ? ST_U_NX : ST_U_RD;
         ST_U_NX:     state_in = step_end ? ST_U_WB : ST_U_NCHK;
         ST_U_NCHK:   state_in = merge_ok ? ST_U_NX : ST_U_WB;
         ST_U_WB:     state_in = ST_U_RD;
         ST_DONE:     if (rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
      if (csr_xfer) state_in = ST_CLEAR;
   end

   // Memory port and result hand-off
   always_comb begin
      mem_req.we    = 1'b0;
      mem_req.waddr = off_ff[ADDR_W-1:0];
      mem_req.wdata = cur_ff;
      mem_req.raddr = off_ff[ADDR_W-1:0];
      rsp_load      = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_ff;
            mem_req.wdata = '0;
         end
         ST_INIT: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = '0;
            mem_req.wdata = '{start: 1'b1, free: 1'b1,
                              size: SIZE_W'(heap_w_ff - OFF_W'(HDR_W))};
         end
         ST_LOOK:   mem_req.raddr = look_off;
         ST_F_MARK: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = old_off_ff[ADDR_W-1:0];
            mem_req.wdata = '{start: 1'b1, free: 1'b1, size: old_size_ff};
         end
         ST_SPLIT: begin
            mem_req.we = 1'b1;
            if (alu_out.split_ok) begin
               mem_req.waddr = alu_out.tail[ADDR_W-1:0];
               mem_req.wdata = '{start: 1'b1, free: 1'b1, size: alu_out.rest};
            end else begin
               mem_req.wdata = '{start: 1'b1, free: keep_free_ff, size: cur_ff.size};
            end
         end
         ST_SPLIT_B: begin
            mem_req.we    = 1'b1;
            mem_req.wdata = '{start: 1'b1, free: keep_free_ff,
                              size: need_ff[SIZE_W-1:0]};
         end
         ST_POST: begin
            if (mode_ff == MODE_GROW) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = old_off_ff[ADDR_W-1:0];
               mem_req.wdata = '{start: 1'b1, free: 1'b1, size: old_size_ff};
            end
         end
         ST_U_NX:   mem_req.raddr = alu_out.step[ADDR_W-1:0];
         ST_U_NCHK: begin
            mem_req.we    = merge_ok;
            mem_req.waddr = nx_ff[ADDR_W-1:0];
            mem_req.wdata = '0;
         end
         ST_U_WB:   mem_req.we = 1'b1;
         ST_DONE:   rsp_load = rsp_free;
         default: begin
         end
      endcase
   end

   assign rsp_data.status = status_ff;
   assign rsp_data.offset = (status_ff == STATUS_DONE) ? res_ff : '0;
   assign rsp_data.moved  = (status_ff == STATUS_DONE) & moved_ff;

   // Datapath register updates
   always_comb begin
      heap_w_in    = heap_w_ff;
      clr_in       = clr_ff;
      mode_in      = mode_ff;
      p_in         = p_ff;
      need_in      = need_ff;
      off_in       = off_ff;
      cur_in       = cur_ff;
      old_off_in   = old_off_ff;
      old_size_in  = old_size_ff;
      keep_free_in = keep_free_ff;
      nx_in        = nx_ff;
      status_in    = status_ff;
      res_in       = res_ff;
      moved_in     = moved_ff;
      case (state_ff)
         ST_CLEAR: clr_in = clr_ff + ADDR_W'(1);
         ST_IDLE: begin
            if (req_xfer) begin
               p_in         = req_payload_offset;
               // Rounding past 17 bits saturates, so no block ever fits
               need_in      = need_sum[BYTES_W] ? '1 : need_sum[OFF_W+1:2];
               off_in       = '0;
               status_in    = STATUS_DONE;
               res_in       = '0;
               moved_in     = 1'b0;
               keep_free_in = 1'b0;
               if (req_kind == KIND_FREE) begin
                  mode_in = MODE_FREE;
               end else if (req_kind == KIND_REALLOC && req_payload_offset != '0) begin
                  mode_in = MODE_SHRINK;
               end else begin
                  mode_in = MODE_ALLOC;
                  if (req_request_bytes == '0 && req_kind != KIND_FREE
                      && (req_kind == KIND_ALLOC || req_kind == KIND_REALLOC)) begin
                     status_in = STATUS_ZERO_SIZE;
                  end
               end
            end
         end
         ST_LOOK: begin
            if (p_ok) off_in = {1'b0, look_off};
            else status_in = STATUS_BAD_OFFSET;
         end
         ST_LOOK_CHK: begin
            if (!rdata.start) begin
               status_in = STATUS_BAD_OFFSET;
            end else begin
               cur_in       = rdata;
               old_off_in   = off_ff;
               old_size_in  = rdata.size;
               keep_free_in = rdata.free;
               if (mode_ff == MODE_SHRINK && !alu_out.fits) begin
                  mode_in      = MODE_GROW;
                  off_in       = '0;
                  keep_free_in = 1'b0;
               end
               if (mode_ff == MODE_FREE) off_in = '0;
            end
         end
         ST_A_RD: if (at_end) status_in = STATUS_NO_FIT;
         ST_A_CHK: begin
            cur_in = rdata;
            if (!(rdata.free && alu_out.fits)) off_in = alu_out.step[OFF_W-1:0];
         end
         ST_POST: begin
            if (mode_ff == MODE_SHRINK) begin
               res_in = p_ff;
            end else begin
               res_in = {grant_w, 2'b00};
            end
            if (mode_ff == MODE_GROW) begin
               moved_in = 1'b1;
               off_in   = '0;
            end
         end
         ST_U_CHK: begin
            cur_in = rdata;
            if (!rdata.free) off_in = alu_out.step[OFF_W-1:0];
         end
         ST_U_NX:   if (!step_end) nx_in = alu_out.step[OFF_W-1:0];
         ST_U_NCHK: if (merge_ok) cur_in.size = alu_out.step[SIZE_W-1:0];
         ST_U_WB:   off_in = alu_out.step[OFF_W-1:0];
         default: begin
         end
      endcase
      if (csr_xfer) begin
         heap_w_in = heap_words(csr_heap_bytes);
         clr_in    = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         heap_w_ff <= OFF_W'(HEAP_RESET / 4);
         clr_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         heap_w_ff <= heap_w_in;
         clr_ff    <= clr_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      p_ff         <= p_in;
      need_ff      <= need_in;
      off_ff       <= off_in;
      cur_ff       <= cur_in;
      old_off_ff   <= old_off_in;
      old_size_ff  <= old_size_in;
      keep_free_ff <= keep_free_in;
      nx_ff        <= nx_in;
      status_ff    <= status_in;
      res_ff       <= res_in;
      moved_ff     <= moved_in;
   end

   a_csr_restarts_clear: assert property (@(posedge clock) disable iff (reset)
      csr_xfer |=> (state_ff == ST_CLEAR) && (clr_ff == '0))
      else $error("heap write did not restart the clearing pass");

   a_split_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPLIT) |-> alu_out.fits)
      else $error("split entered on a block that does not fit");

   a_merge_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_U_NCHK) |-> (nx_ff < heap_w_ff))
      else $error("merge candidate lies beyond the heap");

   a_grow_moves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POST && mode_ff == MODE_GROW) |-> (old_off_ff != off_ff))
      else $error("grow granted the old block again");

endmodule

>>> design/first_fit_heap_allocator.sv
// First-fit heap allocator: top level with the result register.
//
// Requests arrive on the req_ channel (kind, payload_offset, request_bytes);
// one result per request leaves on the rsp_ channel (status, result_offset,
// moved). The csr_ channel writes heap_bytes, which resets the heap to one
// free block. Block headers sit in a 16384-entry memory, one per 4-byte word.
//
// The sequencer walks the block chain, reading and checking each block it
// visits, then splits and marks; a free or a growing reallocate also walks the
// chain once more to merge each free block with the free blocks that follow it.
// The block takes one request at a time: req_ready is high only while idle.
//
// After reset, and after every heap_bytes write, a clearing pass sweeps the
// header memory; no request is taken meanwhile. Reset sets heap_bytes to 4096.
//
// A result waits in the output register while rsp_ready is low; the
// sequencer holds its last step until the register frees.
module first_fit_heap_allocator import ffha_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic [PTR_W-1:0]   req_payload_offset,
   input  logic [BYTES_W-1:0] req_request_bytes,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic [PTR_W-1:0]   rsp_result_offset,
   output logic               rsp_moved,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [BYTES_W-1:0] csr_heap_bytes
);

   alu_in_type  alu_in;
   alu_out_type alu_out;
   mem_req_type mem_req;
   entry_type   rdata;
   rsp_type     rsp_data;
   logic        rsp_load, rsp_free;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   ffha_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   ffha_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rdata)
   );

   ffha_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_payload_offset (req_payload_offset),
      .req_request_bytes  (req_request_bytes),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_heap_bytes     (csr_heap_bytes),
      .rsp_free           (rsp_free),
      .rsp_load           (rsp_load),
      .rsp_data           (rsp_data),
      .alu_in             (alu_in),
      .alu_out            (alu_out),
      .mem_req            (mem_req),
      .rdata              (rdata)
   );

   // Output register: free when empty or being taken this cycle
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_result_offset = rsp_ff.offset;
   assign rsp_moved         = rsp_ff.moved;

endmodule
